[hdl/baro_temp_pressure_compensate_defines.svh]
// Assertion macros shared by the barometric compensation RTL.
`ifndef BARO_TEMP_PRESSURE_COMPENSATE_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTPC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btpc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BTPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btpc assertion failed");

`endif

[hdl/btpc_pkg.sv]
// Constants shared by the barometric temperature and pressure compensation block.
`default_nettype none
package btpc_pkg;

    localparam logic [1:0] CFG_TEMP_COEFFS  = 2'd0;
    localparam logic [1:0] CFG_PRESS_A      = 2'd1;
    localparam logic [1:0] CFG_PRESS_B      = 2'd2;
    localparam logic [1:0] CFG_PRESS_NINE   = 2'd3;

    localparam int          PRE_STAGES      = 10;
    localparam int          DIV_STEPS       = 64;
    localparam int          POST_STAGES     = 5;
    localparam int          NUM_STAGES      = PRE_STAGES + DIV_STEPS + POST_STAGES;

    localparam logic signed [32:0] TFINE_OFFSET   = 33'sd128000;
    localparam logic        [20:0] RAW_FULL_SCALE = 21'd1048576;
    localparam logic signed [63:0] PRESS_SCALE    = 64'sd3125;
    localparam logic signed [63:0] DIVISOR_BIAS   = 64'sh0000_8000_0000_0000;
    localparam logic signed [35:0] TEMP_ROUND     = 36'sd128;
    localparam logic signed [35:0] TEMP_MULT      = 36'sd5;
    localparam logic signed [27:0] TEMP_MIN       = -28'sd32768;
    localparam logic signed [27:0] TEMP_MAX       = 28'sd32767;

endpackage
`default_nettype wire

[hdl/baro_temp_pressure_compensate.sv]
// Pipelined integer temperature and pressure compensation for a barometric sensor.
//
// Channel  Direction  Contents
// s_*      in         tdata: raw_temperature[19:0], raw_pressure[39:20]
// m_*      out        tdata: temperature_centideg[15:0], pressure_q24_8[47:16];
//                     tuser: divide_fault
// cfg_*    in         write enable, register index, 64-bit write data
//
// An item is accepted every cycle while the output is not stalled, and its result is offered
// once it has passed the pre-divide, divider and post-divide stages.
// The 64-step signed divider forms one quotient bit per stage.
// Reset clears the valid bits and the coefficient registers.
// When a result waits at the output, the whole pipeline holds and input is not taken.
`default_nettype none
`include "baro_temp_pressure_compensate_defines.svh"
module baro_temp_pressure_compensate
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // temperature_centideg[15:0], pressure_q24_8[47:16]
    output logic             m_tuser,   // divide_fault
    input  wire logic        cfg_wen,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata
);

    localparam int NST   = btpc_pkg::NUM_STAGES;
    localparam int NDIV  = btpc_pkg::DIV_STEPS;
    localparam int TLEN  = NST - 4;
    localparam int FLEN  = NST - btpc_pkg::PRE_STAGES + 1;

    logic [47:0] temp_cfg_reg;
    logic [63:0] pa_cfg_reg;
    logic [63:0] pb_cfg_reg;
    logic [15:0] p9_cfg_reg;

    logic [NST-1:0] vld_reg;
    logic           en;

    logic        [15:0] t1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    logic        [15:0] p1;

    logic signed [17:0] s1_d1_reg, s1_d1_next;
    logic signed [16:0] s1_d2_reg, s1_d2_next;
    logic        [19:0] adcp_reg [0:6];
    logic signed [33:0] s2_pa_reg, s2_pa_next;
    logic signed [33:0] s2_sq_reg, s2_sq_next;
    logic signed [22:0] s3_ta_reg, s3_ta_next;
    logic signed [37:0] s3_tb_reg, s3_tb_next;
    logic signed [31:0] s4_tf_reg, s4_tf_next;
    logic signed [32:0] s5_a_reg, s5_a_next;
    logic        [15:0] temp_next;
    logic signed [35:0] tc_full;
    logic signed [27:0] tc;
    logic signed [63:0] s6_aa_reg, s6_aa_next, s6_ap5_reg, s6_ap5_next, s6_ap2_reg, s6_ap2_next;
    logic signed [63:0] s7_b6_reg, s7_b6_next, s7_a3_reg, s7_a3_next;
    logic signed [63:0] s7_ap5_reg, s7_ap2_reg;
    logic signed [63:0] s8_b_reg, s8_b_next, s8_a_reg, s8_a_next;
    logic        [20:0] s8_pp_reg, s8_pp_next;
    logic signed [63:0] s9_dv_reg, s9_dv_next, s9_num_reg, s9_num_next;
    logic signed [63:0] divisor;
    logic        [63:0] s10_ma_reg, s10_ma_next, s10_mb_reg, s10_mb_next;
    logic               s10_neg_reg, s10_neg_next, fault_next;

    logic [63:0] div_rem_reg  [0:NDIV-1];
    logic [63:0] div_rem_next [0:NDIV-1];
    logic [63:0] div_dq_reg   [0:NDIV-1];
    logic [63:0] div_dq_next  [0:NDIV-1];
    logic [63:0] div_mb_reg   [0:NDIV-1];
    logic        div_neg_reg  [0:NDIV-1];

    logic signed [63:0] q_p_reg, q_p_next;
    logic signed [63:0] x_s_reg, x_s_next, x_m_reg, x_m_next, x_b8_reg, x_b8_next, x_p_reg;
    logic        [63:0] y_ll_reg, y_ll_next;
    logic        [31:0] y_lh_reg, y_lh_next, y_hl_reg, y_hl_next;
    logic signed [63:0] y_b8_reg, y_p_reg;
    logic signed [63:0] z_a9_reg, z_a9_next, z_b8_reg, z_p_reg;
    logic        [63:0] z_prod;
    logic        [31:0] w_press_reg, w_press_next;
    logic signed [63:0] w_sum, w_pf;

    logic [15:0] temp_line_reg  [0:TLEN-1];
    logic        fault_line_reg [0:FLEN-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cfg_reg <= '0;
            pa_cfg_reg   <= '0;
            pb_cfg_reg   <= '0;
            p9_cfg_reg   <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                btpc_pkg::CFG_TEMP_COEFFS: temp_cfg_reg <= cfg_wdata[47:0];
                btpc_pkg::CFG_PRESS_A:     pa_cfg_reg   <= cfg_wdata;
                btpc_pkg::CFG_PRESS_B:     pb_cfg_reg   <= cfg_wdata;
                btpc_pkg::CFG_PRESS_NINE:  p9_cfg_reg   <= cfg_wdata[15:0];
            endcase
        end
    end

    assign t1 = temp_cfg_reg[15:0];
    assign t2 = $signed(temp_cfg_reg[31:16]);
    assign t3 = $signed(temp_cfg_reg[47:32]);
    assign p1 = pa_cfg_reg[15:0];
    assign p2 = $signed(pa_cfg_reg[31:16]);
    assign p3 = $signed(pa_cfg_reg[47:32]);
    assign p4 = $signed(pa_cfg_reg[63:48]);
    assign p5 = $signed(pb_cfg_reg[15:0]);
    assign p6 = $signed(pb_cfg_reg[31:16]);
    assign p7 = $signed(pb_cfg_reg[47:32]);
    assign p8 = $signed(pb_cfg_reg[63:48]);
    assign p9 = $signed(p9_cfg_reg);

    assign en       = !vld_reg[NST-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = {w_press_reg, temp_line_reg[TLEN-1]};
    assign m_tuser  = fault_line_reg[FLEN-1];

    always_comb
    begin
        s1_d1_next = $signed({1'b0, s_tdata[19:3]}) - $signed({1'b0, t1, 1'b0});
        s1_d2_next = $signed({1'b0, s_tdata[19:4]}) - $signed({1'b0, t1});
        s2_pa_next = s1_d1_reg * t2;
        s2_sq_next = s1_d2_reg * s1_d2_reg;
        s3_ta_next = s2_pa_reg[33:11];
        s3_tb_next = $signed(s2_sq_reg[33:12]) * t3;
        s4_tf_next = s3_ta_reg + $signed(s3_tb_reg[37:14]);
        tc_full    = s4_tf_reg * btpc_pkg::TEMP_MULT + btpc_pkg::TEMP_ROUND;
        tc         = tc_full[35:8];
        if (tc < btpc_pkg::TEMP_MIN)
        begin
            temp_next = 16'h8000;
        end
        else if (tc > btpc_pkg::TEMP_MAX)
        begin
            temp_next = 16'h7FFF;
        end
        else
        begin
            temp_next = tc[15:0];
        end
        s5_a_next   = s4_tf_reg - btpc_pkg::TFINE_OFFSET;
        s6_aa_next  = s5_a_reg * s5_a_reg;
        s6_ap5_next = s5_a_reg * p5;
        s6_ap2_next = s5_a_reg * p2;
        s7_b6_next  = s6_aa_reg * p6;
        s7_a3_next  = s6_aa_reg * p3;
        s8_b_next   = s7_b6_reg + {s7_ap5_reg[46:0], 17'd0}
                    + {p4[15:0], 35'd0}
                    + {{13{p4[15]}}, 51'd0};
        s8_a_next   = (s7_a3_reg >>> 8) + $signed({s7_ap2_reg[51:0], 12'd0});
        s8_pp_next  = btpc_pkg::RAW_FULL_SCALE - {1'b0, adcp_reg[6]};
        s9_dv_next  = (s8_a_reg + btpc_pkg::DIVISOR_BIAS) * $signed({48'd0, p1});
        s9_num_next = ($signed({12'd0, s8_pp_reg, 31'd0}) - s8_b_reg) * btpc_pkg::PRESS_SCALE;
        divisor      = s9_dv_reg >>> 33;
        s10_ma_next  = s9_num_reg[63] ? 64'(-s9_num_reg) : s9_num_reg;
        s10_mb_next  = divisor[63] ? 64'(-divisor) : divisor;
        s10_neg_next = s9_num_reg[63] ^ divisor[63];
        fault_next   = (divisor == 64'sd0);
    end

    always_comb
    begin
        logic [64:0] trial;
        logic [63:0] rem_in;
        logic [63:0] dq_in;
        logic [63:0] mb_in;
        for (int k = 0; k < NDIV; k++)
        begin
            rem_in = (k == 0) ? 64'd0 : div_rem_reg[(k == 0) ? 0 : k - 1];
            dq_in  = (k == 0) ? s10_ma_reg : div_dq_reg[(k == 0) ? 0 : k - 1];
            mb_in  = (k == 0) ? s10_mb_reg : div_mb_reg[(k == 0) ? 0 : k - 1];
            trial  = {rem_in, dq_in[63]};
            if (trial >= {1'b0, mb_in})
            begin
                div_rem_next[k] = 64'(trial - {1'b0, mb_in});
                div_dq_next[k]  = {dq_in[62:0], 1'b1};
            end
            else
            begin
                div_rem_next[k] = trial[63:0];
                div_dq_next[k]  = {dq_in[62:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        q_p_next  = div_neg_reg[NDIV-1] ? -$signed(div_dq_reg[NDIV-1])
                                        : $signed(div_dq_reg[NDIV-1]);
        x_s_next  = q_p_reg >>> 13;
        x_m_next  = p9 * (q_p_reg >>> 13);
        x_b8_next = (p8 * q_p_reg) >>> 19;
        y_ll_next = x_m_reg[31:0] * x_s_reg[31:0];
        y_lh_next = 32'(x_m_reg[31:0] * x_s_reg[63:32]);
        y_hl_next = 32'(x_m_reg[63:32] * x_s_reg[31:0]);
        z_prod    = y_ll_reg + {32'(y_lh_reg + y_hl_reg), 32'd0};
        z_a9_next = $signed(z_prod) >>> 25;
        w_sum     = z_p_reg + z_a9_reg + z_b8_reg;
        w_pf      = (w_sum >>> 8) + $signed({{44{p7[15]}}, p7, 4'd0});
        if (fault_line_reg[FLEN-2] || w_pf[63])
        begin
            w_press_next = 32'd0;
        end
        else if (w_pf[63:32] != 32'd0)
        begin
            w_press_next = 32'hFFFF_FFFF;
        end
        else
        begin
            w_press_next = w_pf[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_d1_reg   <= s1_d1_next;
            s1_d2_reg   <= s1_d2_next;
            adcp_reg[0] <= s_tdata[39:20];
            for (int i = 1; i < 7; i++)
            begin
                adcp_reg[i] <= adcp_reg[i-1];
            end
            s2_pa_reg   <= s2_pa_next;
            s2_sq_reg   <= s2_sq_next;
            s3_ta_reg   <= s3_ta_next;
            s3_tb_reg   <= s3_tb_next;
            s4_tf_reg   <= s4_tf_next;
            s5_a_reg    <= s5_a_next;
            s6_aa_reg   <= s6_aa_next;
            s6_ap5_reg  <= s6_ap5_next;
            s6_ap2_reg  <= s6_ap2_next;
            s7_b6_reg   <= s7_b6_next;
            s7_a3_reg   <= s7_a3_next;
            s7_ap5_reg  <= s6_ap5_reg;
            s7_ap2_reg  <= s6_ap2_reg;
            s8_b_reg    <= s8_b_next;
            s8_a_reg    <= s8_a_next;
            s8_pp_reg   <= s8_pp_next;
            s9_dv_reg   <= s9_dv_next;
            s9_num_reg  <= s9_num_next;
            s10_ma_reg  <= s10_ma_next;
            s10_mb_reg  <= s10_mb_next;
            s10_neg_reg <= s10_neg_next;
            for (int k = 0; k < NDIV; k++)
            begin
                div_rem_reg[k] <= div_rem_next[k];
                div_dq_reg[k]  <= div_dq_next[k];
                div_mb_reg[k]  <= (k == 0) ? s10_mb_reg : div_mb_reg[(k == 0) ? 0 : k - 1];
                div_neg_reg[k] <= (k == 0) ? s10_neg_reg : div_neg_reg[(k == 0) ? 0 : k - 1];
            end
            q_p_reg     <= q_p_next;
            x_s_reg     <= x_s_next;
            x_m_reg     <= x_m_next;
            x_b8_reg    <= x_b8_next;
            x_p_reg     <= q_p_reg;
            y_ll_reg    <= y_ll_next;
            y_lh_reg    <= y_lh_next;
            y_hl_reg    <= y_hl_next;
            y_b8_reg    <= x_b8_reg;
            y_p_reg     <= x_p_reg;
            z_a9_reg    <= z_a9_next;
            z_b8_reg    <= y_b8_reg;
            z_p_reg     <= y_p_reg;
            w_press_reg <= w_press_next;
            temp_line_reg[0]  <= temp_next;
            for (int i = 1; i < TLEN; i++)
            begin
                temp_line_reg[i] <= temp_line_reg[i-1];
            end
            fault_line_reg[0] <= fault_next;
            for (int i = 1; i < FLEN; i++)
            begin
                fault_line_reg[i] <= fault_line_reg[i-1];
            end
        end
    end

    `BTPC_ASSERT_NOW(a_fault_zero, m_tvalid && m_tuser, m_tdata[47:16] == 32'd0)
    `BTPC_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_reg[0])
    `BTPC_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, $stable(vld_reg))

endmodule
`default_nettype wire
